// ----- rtl/core/sogi_pll_grid_sync_unit_defines.svh -----
// Assertion macros shared by the grid sync unit RTL.
`ifndef SOGI_PLL_GRID_SYNC_UNIT_DEFINES_SVH
`define SOGI_PLL_GRID_SYNC_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPLL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/spll_pkg.sv -----
// Types, constants, sine table and micro-op program for the grid sync unit.
package spll_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int SIG_W            = 16;
  localparam int STEP_W           = 31;
  localparam int PHASE_W          = 32;
  localparam int HIST_W           = 32;
  localparam int IN_W             = 48;
  localparam int OUT_W            = 128;
  localparam int CFG_IDX_W        = 3;
  localparam int OPA_W            = 33;
  localparam int OPB_W            = 17;
  localparam int PROD_W           = OPA_W + OPB_W;
  localparam int ACC_W            = 52;

  localparam logic [STEP_W-1:0]  NOMINAL_STEP = 31'd21474836;
  localparam logic [STEP_W-1:0]  STEP_MIN_RST = 31'd19327352;
  localparam logic [STEP_W-1:0]  STEP_MAX_RST = 31'd23622320;
  localparam logic [PHASE_W-1:0] QUARTER      = 32'h4000_0000;
  localparam logic [SIG_W-1:0]   SIG_MAX      = 16'h7FFF;
  localparam longint             HALF_PI_Q30  = 64'sd1686629713;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [SIG_W-1:0] sine_lut_t [SINE_TABLE_DEPTH];

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_GAIN = 3'd0,
    REG_LAG_GAIN    = 3'd1,
    REG_FEEDBACK_1  = 3'd2,
    REG_FEEDBACK_2  = 3'd3,
    REG_PROP_GAIN   = 3'd4,
    REG_INT_GAIN    = 3'd5,
    REG_STEP_MIN    = 3'd6,
    REG_STEP_MAX    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SIG_W-1:0] fg;
    logic signed [SIG_W-1:0] lg;
    logic signed [SIG_W-1:0] f1;
    logic signed [SIG_W-1:0] f2;
    logic [SIG_W-1:0]        pg;
    logic [SIG_W-1:0]        ig;
    logic [STEP_W-1:0]       smin;
    logic [STEP_W-1:0]       smax;
  } spll_cfg_t;

  typedef enum logic [4:0] {
    A_DIFF_AL, A_DIFF_BE,
    A_AL, A_NEG_ADL1, A_AIH0, A_AIH1, A_ADL0, A_AQH0, A_AQH1,
    A_BE, A_NEG_BDL1, A_BIH0, A_BIH1, A_BDL0, A_BQH0, A_BQH1,
    A_AI, A_NEG_BQ, A_AQ, A_BI, A_PA, A_PB, A_QDIFF, A_Q, A_STEP
  } a_src_e;

  typedef enum logic [3:0] {
    B_THIRD, B_ISQ3, B_FG, B_LG, B_F1, B_F2, B_ONE,
    B_COS, B_SIN, B_NEG_SIN, B_PG, B_IG
  } b_src_e;

  typedef enum logic [3:0] {
    D_AL, D_BE, D_AI, D_AQ, D_BI, D_BQ, D_PA, D_PB, D_D, D_Q, D_STEP
  } dest_e;

  typedef struct packed {
    a_src_e a;
    b_src_e b;
    logic   last;
    dest_e  dst;
  } spll_op_t;

  localparam int NUM_OPS = 27;
  localparam int OP_W    = $clog2(NUM_OPS);
  localparam logic [OP_W-1:0] LAST_OP = OP_W'(NUM_OPS - 1);

  typedef struct packed {
    logic            accept;
    logic            mul;
    logic            acc;
    logic            fin;
    logic            finish;
    logic [OP_W-1:0] op;
  } spll_cmd_t;

  typedef struct packed {
    logic out_busy;
  } spll_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_FIN, ST_DONE
  } ctrl_state_e;

  // Quarter-wave sine, Taylor series in Q30, rounded to Q1.15.
  function automatic sine_lut_t build_sine();
    sine_lut_t t;
    longint x, x2, term, sum, v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >>> 30;
      term = x;
      sum = x;
      term = -((term * x2) / 64'sd1073741824) / 64'sd6;
      sum += term;
      term = -((term * x2) / 64'sd1073741824) / 64'sd20;
      sum += term;
      term = -((term * x2) / 64'sd1073741824) / 64'sd42;
      sum += term;
      term = -((term * x2) / 64'sd1073741824) / 64'sd72;
      sum += term;
      term = -((term * x2) / 64'sd1073741824) / 64'sd110;
      sum += term;
      term = -((term * x2) / 64'sd1073741824) / 64'sd156;
      sum += term;
      term = -((term * x2) / 64'sd1073741824) / 64'sd210;
      sum += term;
      if (sum < 0) sum = 0;
      v = (sum * 64'sd32768 + 64'sd536870912) >>> 30;
      if (v > 64'sd32767) v = 64'sd32767;
      t[i] = SIG_W'(v);
    end
    return t;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine();

  function automatic logic signed [SIG_W-1:0] table_sin(input logic [PHASE_W-1:0] p);
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] j;
    logic [SIG_W-1:0] v;
    k = p[PHASE_W-3 -: IDX_W];
    j = IDX_W'(SINE_TABLE_DEPTH) - k;
    if (p[PHASE_W-2]) v = (k == '0) ? SIG_MAX : SINE_LUT[j];
    else v = SINE_LUT[k];
    return p[PHASE_W-1] ? -$signed(v) : $signed(v);
  endfunction

  // Round half up, then drop n fraction bits.
  function automatic acc_t rnd(input acc_t x, input int n);
    return (x + (acc_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [SIG_W-1:0] sat16(input acc_t x);
    if (x > acc_t'(32767)) return 16'sh7FFF;
    if (x < acc_t'(-32768)) return 16'sh8000;
    return x[SIG_W-1:0];
  endfunction

  function automatic logic signed [HIST_W-1:0] sat32(input acc_t x);
    if (x > acc_t'(2147483647)) return 32'sh7FFF_FFFF;
    if (x < acc_t'(-64'sd2147483648)) return 32'sh8000_0000;
    return x[HIST_W-1:0];
  endfunction

  // Micro-op program: each op is one multiply-accumulate; last closes a job.
  function automatic spll_op_t op_entry(input logic [OP_W-1:0] op);
    spll_op_t e;
    case (op)
      5'd0:    e = '{A_DIFF_AL,  B_THIRD,   1'b1, D_AL};
      5'd1:    e = '{A_DIFF_BE,  B_ISQ3,    1'b1, D_BE};
      5'd2:    e = '{A_AL,       B_FG,      1'b0, D_AI};
      5'd3:    e = '{A_NEG_ADL1, B_FG,      1'b0, D_AI};
      5'd4:    e = '{A_AIH0,     B_F1,      1'b0, D_AI};
      5'd5:    e = '{A_AIH1,     B_F2,      1'b1, D_AI};
      5'd6:    e = '{A_ADL0,     B_LG,      1'b0, D_AQ};
      5'd7:    e = '{A_AQH0,     B_F1,      1'b0, D_AQ};
      5'd8:    e = '{A_AQH1,     B_F2,      1'b1, D_AQ};
      5'd9:    e = '{A_BE,       B_FG,      1'b0, D_BI};
      5'd10:   e = '{A_NEG_BDL1, B_FG,      1'b0, D_BI};
      5'd11:   e = '{A_BIH0,     B_F1,      1'b0, D_BI};
      5'd12:   e = '{A_BIH1,     B_F2,      1'b1, D_BI};
      5'd13:   e = '{A_BDL0,     B_LG,      1'b0, D_BQ};
      5'd14:   e = '{A_BQH0,     B_F1,      1'b0, D_BQ};
      5'd15:   e = '{A_BQH1,     B_F2,      1'b1, D_BQ};
      5'd16:   e = '{A_AI,       B_ONE,     1'b0, D_PA};
      5'd17:   e = '{A_NEG_BQ,   B_ONE,     1'b1, D_PA};
      5'd18:   e = '{A_AQ,       B_ONE,     1'b0, D_PB};
      5'd19:   e = '{A_BI,       B_ONE,     1'b1, D_PB};
      5'd20:   e = '{A_PA,       B_COS,     1'b0, D_D};
      5'd21:   e = '{A_PB,       B_SIN,     1'b1, D_D};
      5'd22:   e = '{A_PB,       B_COS,     1'b0, D_Q};
      5'd23:   e = '{A_PA,       B_NEG_SIN, 1'b1, D_Q};
      5'd24:   e = '{A_STEP,     B_ONE,     1'b0, D_STEP};
      5'd25:   e = '{A_QDIFF,    B_PG,      1'b0, D_STEP};
      5'd26:   e = '{A_Q,        B_IG,      1'b1, D_STEP};
      default: e = '{A_STEP,     B_ONE,     1'b1, D_STEP};
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/core/spll_cfg.sv -----
// Configuration register file of the grid sync unit.
module spll_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [spll_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [spll_pkg::STEP_W-1:0]    cfg_data_i,
  output spll_pkg::spll_cfg_t            cfg_o
);
  import spll_pkg::*;

  spll_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FILTER_GAIN: cfg_d.fg   = cfg_data_i[SIG_W-1:0];
        REG_LAG_GAIN:    cfg_d.lg   = cfg_data_i[SIG_W-1:0];
        REG_FEEDBACK_1:  cfg_d.f1   = cfg_data_i[SIG_W-1:0];
        REG_FEEDBACK_2:  cfg_d.f2   = cfg_data_i[SIG_W-1:0];
        REG_PROP_GAIN:   cfg_d.pg   = cfg_data_i[SIG_W-1:0];
        REG_INT_GAIN:    cfg_d.ig   = cfg_data_i[SIG_W-1:0];
        REG_STEP_MIN:    cfg_d.smin = cfg_data_i;
        REG_STEP_MAX:    cfg_d.smax = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{fg: '0, lg: '0, f1: '0, f2: '0, pg: '0, ig: '0,
                 smin: STEP_MIN_RST, smax: STEP_MAX_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/spll_ctrl.sv -----
// Sequencer that walks the micro-op program for one sample.
module spll_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  spll_pkg::spll_sts_t sts_i,
  output logic                in_ready_o,
  output spll_pkg::spll_cmd_t cmd_o
);
  import spll_pkg::*;

  ctrl_state_e     state_q, state_d;
  logic [OP_W-1:0] op_q, op_d;
  spll_op_t        ent;

  assign ent = op_entry(op_q);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
          op_d    = '0;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (ent.last) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL;
          op_d    = op_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (op_q == LAST_OP) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
          op_d    = op_q + 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the beat
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = op_q;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_MUL:  cmd_o.mul    = 1'b1;
      ST_ACC:  cmd_o.acc    = 1'b1;
      ST_FIN:  cmd_o.fin    = 1'b1;
      ST_DONE: cmd_o.finish = !sts_i.out_busy;
      default: cmd_o.op     = op_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ----- rtl/core/spll_dpath.sv -----
// Datapath: shared multiply-accumulate, SOGI and PLL state, output register.
module spll_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spll_pkg::spll_cmd_t          cmd_i,
  input  spll_pkg::spll_cfg_t          cfg_i,
  input  logic [spll_pkg::IN_W-1:0]    in_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [spll_pkg::OUT_W-1:0]   out_data_o,
  output spll_pkg::spll_sts_t          sts_o
);
  import spll_pkg::*;

  logic signed [SIG_W-1:0]  u_q, v_q, w_q;
  logic signed [SIG_W-1:0]  al_q, be_q, pa_q, pb_q, d_q, q_q, sin_q, cos_q, prev_q;
  logic signed [HIST_W-1:0] ai_q, aq_q, bi_q, bq_q;
  logic signed [SIG_W-1:0]  a_dl0_q, a_dl1_q, b_dl0_q, b_dl1_q;
  logic signed [HIST_W-1:0] a_ih0_q, a_ih1_q, a_qh0_q, a_qh1_q;
  logic signed [HIST_W-1:0] b_ih0_q, b_ih1_q, b_qh0_q, b_qh1_q;
  logic [PHASE_W-1:0]       phase_q;
  logic [STEP_W-1:0]        step_q, nstep_q;
  logic signed [PROD_W-1:0] prod_q;
  acc_t                     acc_q;
  logic                     out_valid_q;
  logic [OUT_W-1:0]         out_data_q;

  spll_op_t                 ent;
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [17:0]       diff_al;
  logic signed [16:0]       diff_be;
  logic signed [16:0]       qdiff;
  acc_t                     st;
  logic [STEP_W-1:0]        st_clamped;
  logic                     zc;

  assign ent     = op_entry(cmd_i.op);
  assign diff_al = 18'(u_q) + 18'(u_q) - 18'(v_q) - 18'(w_q);
  assign diff_be = 17'(v_q) - 17'(w_q);
  assign qdiff   = 17'(q_q) - 17'(prev_q);

  always_comb begin
    case (ent.a)
      A_DIFF_AL:  op_a = OPA_W'(diff_al);
      A_DIFF_BE:  op_a = OPA_W'(diff_be);
      A_AL:       op_a = OPA_W'(al_q);
      A_NEG_ADL1: op_a = -OPA_W'(a_dl1_q);
      A_AIH0:     op_a = OPA_W'(a_ih0_q);
      A_AIH1:     op_a = OPA_W'(a_ih1_q);
      A_ADL0:     op_a = OPA_W'(a_dl0_q);
      A_AQH0:     op_a = OPA_W'(a_qh0_q);
      A_AQH1:     op_a = OPA_W'(a_qh1_q);
      A_BE:       op_a = OPA_W'(be_q);
      A_NEG_BDL1: op_a = -OPA_W'(b_dl1_q);
      A_BIH0:     op_a = OPA_W'(b_ih0_q);
      A_BIH1:     op_a = OPA_W'(b_ih1_q);
      A_BDL0:     op_a = OPA_W'(b_dl0_q);
      A_BQH0:     op_a = OPA_W'(b_qh0_q);
      A_BQH1:     op_a = OPA_W'(b_qh1_q);
      A_AI:       op_a = OPA_W'(ai_q);
      A_NEG_BQ:   op_a = -OPA_W'(bq_q);
      A_AQ:       op_a = OPA_W'(aq_q);
      A_BI:       op_a = OPA_W'(bi_q);
      A_PA:       op_a = OPA_W'(pa_q);
      A_PB:       op_a = OPA_W'(pb_q);
      A_QDIFF:    op_a = OPA_W'(qdiff);
      A_Q:        op_a = OPA_W'(q_q);
      A_STEP:     op_a = $signed({2'b00, step_q});
      default:    op_a = '0;
    endcase
  end

  always_comb begin
    case (ent.b)
      B_THIRD:   op_b = 17'sd21845;
      B_ISQ3:    op_b = 17'sd37837;
      B_FG:      op_b = OPB_W'(cfg_i.fg);
      B_LG:      op_b = OPB_W'(cfg_i.lg);
      B_F1:      op_b = OPB_W'(cfg_i.f1);
      B_F2:      op_b = OPB_W'(cfg_i.f2);
      B_ONE:     op_b = 17'sd1;
      B_COS:     op_b = OPB_W'(cos_q);
      B_SIN:     op_b = OPB_W'(sin_q);
      B_NEG_SIN: op_b = -OPB_W'(sin_q);
      B_PG:      op_b = $signed({1'b0, cfg_i.pg});
      B_IG:      op_b = $signed({1'b0, cfg_i.ig});
      default:   op_b = '0;
    endcase
  end

  // Step clamp: max first, then min, so min wins when they cross.
  assign st = acc_q;
  always_comb begin
    st_clamped = st[STEP_W-1:0];
    if (st > acc_t'(cfg_i.smax)) st_clamped = cfg_i.smax;
    if (st > acc_t'(cfg_i.smax) ? (cfg_i.smax < cfg_i.smin) : (st < acc_t'(cfg_i.smin))) begin
      st_clamped = cfg_i.smin;
    end
  end

  assign zc = (phase_q[PHASE_W-1 -: 2] == 2'b00) ||
              ((phase_q[PHASE_W-1 -: 2] == 2'b11) && (phase_q[PHASE_W-3:0] != '0));

  // Input capture, product, job results, trig lookups and output payload.
  always_ff @(posedge clk_i) begin
    sin_q <= table_sin(phase_q);
    cos_q <= table_sin(phase_q + QUARTER);
    if (cmd_i.accept) begin
      u_q <= in_data_i[SIG_W-1:0];
      v_q <= in_data_i[2*SIG_W-1:SIG_W];
      w_q <= in_data_i[3*SIG_W-1:2*SIG_W];
    end
    if (cmd_i.mul) prod_q <= op_a * op_b;
    if (cmd_i.fin) begin
      case (ent.dst)
        D_AL:    al_q    <= sat16(rnd(acc_q, 16));
        D_BE:    be_q    <= sat16(rnd(acc_q, 16));
        D_AI:    ai_q    <= sat32(rnd(acc_q, 14));
        D_AQ:    aq_q    <= sat32(rnd(acc_q, 14));
        D_BI:    bi_q    <= sat32(rnd(acc_q, 14));
        D_BQ:    bq_q    <= sat32(rnd(acc_q, 14));
        D_PA:    pa_q    <= sat16(rnd(acc_q, 1));
        D_PB:    pb_q    <= sat16(rnd(acc_q, 1));
        D_D:     d_q     <= sat16(rnd(acc_q, 15));
        D_Q:     q_q     <= sat16(rnd(acc_q, 15));
        D_STEP:  nstep_q <= st_clamped;
        default: nstep_q <= nstep_q;
      endcase
    end
    if (cmd_i.finish) begin
      out_data_q <= {zc, nstep_q, phase_q, sin_q, cos_q, q_q, d_q};
    end
  end

  // Accumulator, loop state, filter histories and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      phase_q     <= '0;
      step_q      <= NOMINAL_STEP;
      prev_q      <= '0;
      a_dl0_q     <= '0;
      a_dl1_q     <= '0;
      b_dl0_q     <= '0;
      b_dl1_q     <= '0;
      a_ih0_q     <= '0;
      a_ih1_q     <= '0;
      a_qh0_q     <= '0;
      a_qh1_q     <= '0;
      b_ih0_q     <= '0;
      b_ih1_q     <= '0;
      b_qh0_q     <= '0;
      b_qh1_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.fin) acc_q <= '0;
      else if (cmd_i.acc) acc_q <= acc_q + ACC_W'(prod_q);
      // advance phase with the step left by the previous sample
      if (cmd_i.accept) phase_q <= phase_q + {1'b0, step_q};
      if (cmd_i.finish) begin
        step_q  <= nstep_q;
        prev_q  <= q_q;
        a_dl1_q <= a_dl0_q;
        a_dl0_q <= al_q;
        b_dl1_q <= b_dl0_q;
        b_dl0_q <= be_q;
        a_ih1_q <= a_ih0_q;
        a_ih0_q <= ai_q;
        a_qh1_q <= a_qh0_q;
        a_qh0_q <= aq_q;
        b_ih1_q <= b_ih0_q;
        b_ih0_q <= bi_q;
        b_qh1_q <= b_qh0_q;
        b_qh0_q <= bq_q;
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

// ----- rtl/core/sogi_pll_grid_sync_unit.sv -----
// Three-phase SOGI PLL grid synchronizer, top level.
// Use: one U/V/W sample per beat on the s_axis channel (Q1.15 each). The
// block forms alpha/beta, runs in-phase and quadrature SOGI filters on both
// axes, builds the positive sequence, advances a 32-bit phase accumulator,
// rotates to d/q and updates the frequency step through an incremental PI.
// One result beat leaves on m_axis per sample: d, q, cos, sin, phase, step
// and the within-90-degrees flag.
// Sequencing: all 27 products of a sample go through one shared
// multiply-accumulate unit, each in a multiply state and then an accumulate
// state; each of the 11 results is then rounded and saturated in a finish state.
// A new sample is taken only after the previous one is done.
// The next sample is taken while a result still waits in the output register;
// if m_axis stays stalled the sequencer holds at the end of that sample.
// Configuration: cfg_index_i selects a register (0..7), written when
// cfg_valid_i is high; cfg_ready_o is always high. Write only while idle.
// Reset: filter histories, phase and last q error clear, step returns to
// nominal, step limits return to their defaults, gains clear to zero.
`include "sogi_pll_grid_sync_unit_defines.svh"

module sogi_pll_grid_sync_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: phase_u [15:0], phase_v [31:16], phase_w [47:32]
  input  logic [spll_pkg::IN_W-1:0]      s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: volt_d [15:0], volt_q [31:16], cos_out [47:32], sin_out [63:48],
  //        phase_out [95:64], freq_step [126:96], zero_cross [127]
  output logic [spll_pkg::OUT_W-1:0]     m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [spll_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [spll_pkg::STEP_W-1:0]    cfg_data_i
);
  import spll_pkg::*;

  spll_cfg_t cfg;
  spll_cmd_t cmd;
  spll_sts_t sts;

  assign cfg_ready_o = 1'b1;

  spll_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  spll_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .sts_o       (sts)
  );

  `SPLL_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a sample is in work")

  `SPLL_ASSERT_NOW(a_step_in_range, m_axis_tvalid && (cfg.smin <= cfg.smax), (m_axis_tdata[126:96] >= cfg.smin) && (m_axis_tdata[126:96] <= cfg.smax), "frequency step outside its limits")

  `SPLL_ASSERT_NOW(a_finish_slot_free, cmd.finish, !m_axis_tvalid || m_axis_tready, "result loaded over a waiting beat")

endmodule
